/* design/rpfa_pkg.sv */
// Package for the reference-counted page frame allocator.
// Holds sizes, operation and status codes, and the channel payload types.
// No dependencies; every other design file except rpfa_ram imports it.
package rpfa_pkg;

  localparam int NUM_PAGES  = 65536;
  localparam int COUNT_BITS = 8;
  localparam int FRAME_W    = 16;
  localparam int REF_W      = 8;
  localparam int PAGE_AW    = $clog2(NUM_PAGES);
  localparam int DEPTH_W    = $clog2(NUM_PAGES + 1);

  typedef enum logic [2:0] {
    KIND_SEED     = 3'd0,
    KIND_ALLOC    = 3'd1,
    KIND_FREE     = 3'd2,
    KIND_REF_UP   = 3'd3,
    KIND_REF_DOWN = 3'd4,
    KIND_REF_GET  = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_RANGE     = 3'd1,
    STAT_NONE_FREE = 3'd2,
    STAT_SATURATED = 3'd3,
    STAT_FULL      = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [FRAME_W-1:0] frame;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] granted_frame;
    logic [REF_W-1:0]   ref_count;
    logic               released;
    status_t            status;
  } rsp_t;

endpackage

/* design/rpfa_if.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on rpfa_pkg for the payload types.
interface rpfa_req_if import rpfa_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rpfa_rsp_if import rpfa_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/rpfa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rpfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    waddr_q;

  assign waddr_q = waddr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr_q] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/refcounted_page_frame_allocator_top.sv */
// Top level of the reference-counted page frame allocator.
// Uses rpfa_pkg, the channel interfaces and two rpfa_ram instances.
//
//   Channel | Direction | Payload                                     | Handshake
//   req     | in        | kind, frame                                 | valid/ready
//   rsp     | out       | granted_frame, ref_count, released, status  | valid/ready
//   cfg     | in        | cfg_wdata (first_frame)                     | cfg_we
//
// Each item has a read step for the count and stack RAMs and a write-back
// step that modifies and writes them back, so at most one item is in flight.
// After rst the count RAM is cleared one entry per cycle (all NUM_PAGES entries,
// 65536); req.ready stays low during that pass, configuration writes are taken.
// A result waits in an output register; the next item is accepted meanwhile and
// holds in its write-back cycle until the output register frees up.
module refcounted_page_frame_allocator_top import rpfa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  rpfa_req_if.sink           req,
  rpfa_rsp_if.source         rsp,
  input  logic               cfg_we,
  input  logic [FRAME_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t               state, state_next;
  logic [PAGE_AW-1:0]   clr_addr;
  logic [2:0]           cur_kind;
  logic [FRAME_W-1:0]   cur_frame;
  logic [DEPTH_W-1:0]   depth, depth_next;
  logic [FRAME_W-1:0]   first_frame;
  logic                 rsp_valid;
  rsp_t                 rsp_data, rsp_data_next;

  logic                 req_fire;
  logic                 out_free;
  logic                 exec_go;
  logic                 frame_ok;
  logic                 stack_full;
  logic                 push;

  logic                 cw_en;
  logic [PAGE_AW-1:0]   cw_addr;
  logic [COUNT_BITS-1:0] cw_data;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [COUNT_BITS-1:0] cnt_out;

  logic                 sw_en;
  logic [FRAME_W-1:0]   top_frame;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !rsp_valid || rsp.ready;
  assign exec_go   = (state == S_EXEC) && out_free;

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  rpfa_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_PAGES)) u_count_ram (
    .clk   (clk),
    .we    (cw_en),
    .waddr (cw_addr),
    .wdata (cw_data),
    .re    (req_fire),
    .raddr (PAGE_AW'(req.data.frame)),
    .rdata (cnt_rd)
  );

  // The top of the stack is read on every accept; only alloc uses it.
  rpfa_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_PAGES)) u_stack_ram (
    .clk   (clk),
    .we    (sw_en),
    .waddr (PAGE_AW'(depth)),
    .wdata (cur_frame),
    .re    (req_fire),
    .raddr (PAGE_AW'(depth - 1'b1)),
    .rdata (top_frame)
  );

  assign frame_ok   = (cur_frame >= first_frame) &&
                      ((DEPTH_W + 1)'(cur_frame) < (DEPTH_W + 1)'(NUM_PAGES));
  assign stack_full = (depth == DEPTH_W'(NUM_PAGES));

  always_comb begin
    cw_en         = 1'b0;
    cw_addr       = PAGE_AW'(cur_frame);
    cw_data       = '0;
    push          = 1'b0;
    cnt_out       = '0;
    depth_next    = depth;
    rsp_data_next = '0;

    if (state == S_CLEAR) begin
      cw_en   = 1'b1;
      cw_addr = clr_addr;
    end else if (exec_go) begin
      if (cur_kind == KIND_ALLOC) begin
        if (depth == '0) begin
          rsp_data_next.status = STAT_NONE_FREE;
        end else begin
          depth_next                  = depth - 1'b1;
          cw_en                       = 1'b1;
          cw_addr                     = PAGE_AW'(top_frame);
          cw_data                     = COUNT_BITS'(1);
          cnt_out                     = COUNT_BITS'(1);
          rsp_data_next.granted_frame = top_frame;
        end
      end else if (cur_kind <= KIND_REF_GET) begin
        if (!frame_ok) begin
          rsp_data_next.status = STAT_RANGE;
        end else begin
          cnt_out = cnt_rd;
          unique case (cur_kind)
            KIND_SEED: begin
              cw_en   = 1'b1;
              cnt_out = '0;
              push    = 1'b1;
            end
            KIND_FREE: begin
              // A free at zero leaves the count at zero and pushes again.
              if (cnt_rd != '0) begin
                cnt_out = cnt_rd - 1'b1;
              end
              cw_en   = 1'b1;
              cw_data = cnt_out;
              push    = (cnt_out == '0);
            end
            KIND_REF_UP: begin
              if (cnt_rd == '1) begin
                rsp_data_next.status = STAT_SATURATED;
              end else begin
                cnt_out = cnt_rd + 1'b1;
                cw_en   = 1'b1;
                cw_data = cnt_out;
              end
            end
            KIND_REF_DOWN: begin
              if (cnt_rd == '0) begin
                rsp_data_next.status = STAT_SATURATED;
              end else begin
                cnt_out = cnt_rd - 1'b1;
                cw_en   = 1'b1;
                cw_data = cnt_out;
              end
            end
            default: begin
            end
          endcase
          if (push) begin
            if (stack_full) begin
              rsp_data_next.status = STAT_FULL;
            end else begin
              depth_next             = depth + 1'b1;
              rsp_data_next.released = 1'b1;
            end
          end
        end
      end
      rsp_data_next.ref_count = REF_W'(cnt_out);
    end
  end

  assign sw_en = push && !stack_full;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == PAGE_AW'(NUM_PAGES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_fire) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      depth       <= '0;
      first_frame <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      depth <= depth_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_we) begin
        first_frame <= cfg_wdata;
      end
      if (exec_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      cur_kind  <= req.data.kind;
      cur_frame <= req.data.frame;
    end
    if (exec_go) begin
      rsp_data <= rsp_data_next;
    end
  end

endmodule

/* design/rpfa_checker.sv */
// Port-level checks for the page frame allocator top level, and their binding.
// Depends on rpfa_pkg and refcounted_page_frame_allocator_top.
module rpfa_port_checks import rpfa_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  // One item in flight: accepting an item closes the request side next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while an item was in flight");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response changed");

  a_released_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.released |-> rsp_data.status == STAT_OK)
    else $error("frame released with an error status");

  a_grant_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.granted_frame != '0 |->
      rsp_data.status == STAT_OK && rsp_data.ref_count == REF_W'(1))
    else $error("granted frame without a count of one");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status == STAT_RANGE || rsp_data.status == STAT_NONE_FREE) |->
      rsp_data.ref_count == '0 && rsp_data.granted_frame == '0 && !rsp_data.released)
    else $error("error response carries nonzero fields");

endmodule

bind refcounted_page_frame_allocator_top rpfa_port_checks u_rpfa_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

/* tb/sv/rpfa_checker.sv */
`timescale 1ns / 1ps
// Response checker for the page frame allocator: predicts every response from the
// requests and configuration writes it observes, then compares in order.
// Depends on rpfa_pkg and the rpfa_req_if / rpfa_rsp_if channel interfaces.
module rpfa_checker import rpfa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  rpfa_req_if                req,
  rpfa_rsp_if                rsp,
  input  logic               cfg_we,
  input  logic [FRAME_W-1:0] cfg_wdata,
  output int unsigned        mismatches,
  output int unsigned        pending
);

  localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;

  logic [COUNT_BITS-1:0] frame_count [NUM_PAGES];
  logic [FRAME_W-1:0]    free_frames [NUM_PAGES];
  logic [DEPTH_W-1:0]    free_depth = '0;
  logic [FRAME_W-1:0]    lowest_frame = '0;
  rsp_t                  expected_rsp_q [$];
  int unsigned           fail_cnt = 0;

  // Returns 0 when the free stack has no room left.
  function automatic logic push_free(logic [FRAME_W-1:0] f);
    if (free_depth >= NUM_PAGES) return 1'b0;
    free_frames[free_depth] = f;
    free_depth++;
    return 1'b1;
  endfunction

  function automatic rsp_t predict_response(req_t rq);
    rsp_t                  r;
    logic [FRAME_W-1:0]    f;
    logic [COUNT_BITS-1:0] c;
    r = '0;
    f = rq.frame;
    if (rq.kind == KIND_ALLOC) begin
      if (free_depth == 0) begin
        r.status = STAT_NONE_FREE;
      end else begin
        free_depth--;
        f = free_frames[free_depth];
        frame_count[f] = 1;
        r.granted_frame = f;
        r.ref_count = 1;
      end
    end else if (rq.kind <= KIND_REF_GET) begin
      if (f < lowest_frame || int'(f) >= NUM_PAGES) begin
        r.status = STAT_RANGE;
      end else begin
        c = frame_count[f];
        case (rq.kind)
          KIND_SEED: begin
            c = '0;
            if (push_free(f)) r.released = 1'b1;
            else r.status = STAT_FULL;
          end
          KIND_FREE: begin
            if (c > 0) c--;
            // A frame that reaches zero goes back on the stack, even if it was zero already.
            if (c == 0) begin
              if (push_free(f)) r.released = 1'b1;
              else r.status = STAT_FULL;
            end
          end
          KIND_REF_UP: begin
            if (c >= COUNT_MAX) r.status = STAT_SATURATED;
            else c++;
          end
          KIND_REF_DOWN: begin
            if (c == 0) r.status = STAT_SATURATED;
            else c--;
          end
          default: begin
          end
        endcase
        frame_count[f] = c;
        r.ref_count = REF_W'(c);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t exp_r;
    if (rst) begin
      for (int i = 0; i < NUM_PAGES; i++) frame_count[i] = '0;
      free_depth = '0;
      lowest_frame = '0;
      expected_rsp_q.delete();
    end else begin
      if (cfg_we) lowest_frame = cfg_wdata;
      // Check the response first so a request taken on the same edge never pairs with it.
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response item with no request outstanding: %h", rsp.data);
          fail_cnt++;
        end else begin
          exp_r = expected_rsp_q.pop_front();
          if (rsp.data.granted_frame !== exp_r.granted_frame) begin
            $error("granted_frame: expected %0d, got %0d",
                   exp_r.granted_frame, rsp.data.granted_frame);
            fail_cnt++;
          end
          if (rsp.data.ref_count !== exp_r.ref_count) begin
            $error("ref_count: expected %0d, got %0d", exp_r.ref_count, rsp.data.ref_count);
            fail_cnt++;
          end
          if (rsp.data.released !== exp_r.released) begin
            $error("released: expected %0d, got %0d", exp_r.released, rsp.data.released);
            fail_cnt++;
          end
          if (rsp.data.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, rsp.data.status);
            fail_cnt++;
          end
        end
      end
      if (req.valid && req.ready) expected_rsp_q.push_back(predict_response(req.data));
    end
    pending <= expected_rsp_q.size();
    mismatches <= fail_cnt;
  end

endmodule

/* tb/sv/tb_refcounted_page_frame_allocator_top.sv */
`timescale 1ns / 1ps
// Testbench top for the page frame allocator: clock, reset, request and
// configuration stimulus, response back-pressure and the verdict. Depends on
// rpfa_pkg, the channel interfaces, the design top and rpfa_checker.
module tb_refcounted_page_frame_allocator_top;
  import rpfa_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we;
  logic [FRAME_W-1:0] cfg_wdata;
  logic [FRAME_W-1:0] cur_first;
  int unsigned        mismatches;
  int unsigned        pending;
  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;

  rpfa_req_if req_ch ();
  rpfa_rsp_if rsp_ch ();

  refcounted_page_frame_allocator_top uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  rpfa_checker frame_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(input logic [2:0] op, input logic [FRAME_W-1:0] frame_no);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= '{kind: op, frame: frame_no};
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Holds the request channel quiet until every predicted response has been taken.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_first_frame(input logic [FRAME_W-1:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_first = value;
  endtask

  // Most frames come from a small pool at the bottom of the managed range so that
  // counts build up and frames cycle through the stack.
  task automatic send_random(output bit counted);
    int unsigned        pick;
    logic [2:0]         op;
    logic [FRAME_W-1:0] fr;
    logic [FRAME_W-1:0] base;
    pick = $urandom_range(99);
    if (pick < 15) op = KIND_SEED;
    else if (pick < 40) op = KIND_ALLOC;
    else if (pick < 60) op = KIND_FREE;
    else if (pick < 75) op = KIND_REF_UP;
    else if (pick < 87) op = KIND_REF_DOWN;
    else if (pick < 97) op = KIND_REF_GET;
    else op = 3'($urandom_range(7, 6));
    base = (cur_first > 16'hFFF8) ? 16'hFFF8 : cur_first;
    pick = $urandom_range(99);
    if (pick < 80) fr = base + 16'($urandom_range(7));
    else if (pick < 90 && cur_first != 0) fr = 16'($urandom_range(cur_first - 1));
    else fr = 16'($urandom);
    send_item(op, fr);
    counted = (op <= KIND_REF_GET);
  endtask

  task automatic random_run(input int unsigned n_items);
    int unsigned sent;
    bit          counted;
    sent = 0;
    while (sent < n_items) begin
      send_random(counted);
      if (counted) sent++;
    end
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cur_first = '0;
    send_idle_pct = 37;
    recv_idle_pct = 66;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    write_first_frame(16'd16);
    send_item(KIND_SEED, 16'd16);
    send_item(KIND_SEED, 16'd17);
    send_item(KIND_SEED, 16'd15);
    send_item(KIND_ALLOC, 16'hFFFF);
    send_item(KIND_ALLOC, 16'd0);
    send_item(KIND_ALLOC, 16'd0);
    send_item(KIND_REF_UP, 16'd16);
    send_item(KIND_REF_UP, 16'd16);
    send_item(KIND_REF_DOWN, 16'd16);
    send_item(KIND_REF_GET, 16'd16);
    send_item(KIND_FREE, 16'd17);
    send_item(KIND_FREE, 16'd17);
    send_item(KIND_REF_DOWN, 16'd18);
    send_item(KIND_REF_UP, 16'd0);
    send_item(KIND_FREE, 16'd15);
    send_item(KIND_REF_GET, 16'hFFFF);
    send_item(3'd6, 16'hFFFF);
    send_item(3'd7, 16'd0);
    send_item(KIND_SEED, 16'hFFFF);
    send_item(KIND_ALLOC, 16'd0);
    send_item(KIND_ALLOC, 16'd0);
    send_item(KIND_ALLOC, 16'd0);
    send_item(KIND_ALLOC, 16'd0);

    // Drive one count into saturation at the top, then down to zero and a refused step below it.
    repeat (256) send_item(KIND_REF_UP, 16'hFFFF);
    repeat (256) send_item(KIND_REF_DOWN, 16'hFFFF);
    send_item(KIND_FREE, 16'hFFFF);

    write_first_frame(16'($urandom_range(60000, 1)));
    random_run(500);

    send_idle_pct = 66;
    recv_idle_pct = 37;
    write_first_frame(16'hFFFF);
    random_run(250);
    write_first_frame(16'd100);
    random_run(250);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_first_frame(16'd0);
    random_run(500);

    // Enough seeds to fill the free stack whatever its depth, then overflow it.
    repeat (NUM_PAGES) send_item(KIND_SEED, 16'd5);
    send_item(KIND_SEED, 16'd6);
    send_item(KIND_FREE, 16'd5);
    repeat (3) send_item(KIND_ALLOC, 16'd0);
    send_item(KIND_SEED, 16'd7);
    send_item(KIND_FREE, 16'd5);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("refcounted_page_frame_allocator_top: match");
    end else begin
      $display("refcounted_page_frame_allocator_top: mismatch");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("refcounted_page_frame_allocator_top: mismatch");
    $finish;
  end

endmodule

/* files.f */
design/rpfa_pkg.sv
design/rpfa_if.sv
design/rpfa_ram.sv
design/refcounted_page_frame_allocator_top.sv
design/rpfa_checker.sv
tb/sv/rpfa_checker.sv
tb/sv/tb_refcounted_page_frame_allocator_top.sv
